@@ sv/msrc_pkg.sv @@
// ---------------------------------------------------------------------------
// msrc_pkg: shared types and constants for the step run controller
// Holds the channel count, counter width, operation codes, the per-channel
// run state encoding and the item and result records.
// ---------------------------------------------------------------------------
`default_nettype none

package msrc_pkg;

  // channel count and step counter width
  localparam int CHANNELS    = 4;
  localparam int COUNT_WIDTH = 16;

  // fixed field widths of the request and result items
  localparam int OP_W    = 2;
  localparam int CH_W    = 2;
  localparam int STEP_W  = 16;
  localparam int VEC_W   = 4;

  // channels that show up in the per-channel bit vectors
  localparam int VIS_CH = (CHANNELS < VEC_W) ? CHANNELS : VEC_W;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_TICK  = 2'd1,
    OP_STEP  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // per-channel run state, one-hot
  typedef enum logic [2:0] {
    RS_STOPPED = 3'b001,
    RS_PENDING = 3'b010,
    RS_RUNNING = 3'b100
  } run_state_t;

  // one input request
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CH_W-1:0]   channel;
    logic [STEP_W-1:0] step_count;
    logic              forward;
  } item_t;

  // one result
  typedef struct packed {
    logic             rejected;
    logic             finished;
    logic [VEC_W-1:0] drive_enable;
    logic [VEC_W-1:0] direction_bits;
    logic [VEC_W-1:0] busy_bits;
  } res_t;

endpackage

`default_nettype wire

@@ sv/msrc_in_if.sv @@
// ---------------------------------------------------------------------------
// msrc_in_if: request channel of the step run controller
// Valid/ready handshake carrying one request per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface msrc_in_if import msrc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CH_W-1:0]   channel;
  logic [STEP_W-1:0] step_count;
  logic              forward;

  modport source (output valid, op, channel, step_count, forward, input ready);
  modport sink   (input valid, op, channel, step_count, forward, output ready);
endinterface

`default_nettype wire

@@ sv/msrc_out_if.sv @@
// ---------------------------------------------------------------------------
// msrc_out_if: result channel of the step run controller
// Valid/ready handshake carrying one result per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface msrc_out_if import msrc_pkg::*;;
  logic             valid;
  logic             ready;
  logic             rejected;
  logic             finished;
  logic [VEC_W-1:0] drive_enable;
  logic [VEC_W-1:0] direction_bits;
  logic [VEC_W-1:0] busy_bits;

  modport source (output valid, rejected, finished, drive_enable, direction_bits,
                  busy_bits, input ready);
  modport sink   (input valid, rejected, finished, drive_enable, direction_bits,
                  busy_bits, output ready);
endinterface

`default_nettype wire

@@ sv/msrc_chan_bank.sv @@
// ---------------------------------------------------------------------------
// msrc_chan_bank: per-channel run state, step counters and directions
// Applies one request per fire cycle to all channels in parallel and
// produces the result as seen after the update.
// ---------------------------------------------------------------------------
`default_nettype none

module msrc_chan_bank import msrc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  fire,
  input  wire item_t item,
  output res_t       res
);

  run_state_t             state_r   [CHANNELS];
  run_state_t             state_nxt [CHANNELS];
  logic [COUNT_WIDTH-1:0] rem_r     [CHANNELS];
  logic [COUNT_WIDTH-1:0] rem_nxt   [CHANNELS];
  logic [CHANNELS-1:0]    dir_r;
  logic [CHANNELS-1:0]    dir_nxt;

  logic [CHANNELS-1:0]    hit;
  logic [CHANNELS-1:0]    start_ok;
  logic [CHANNELS-1:0]    step_end;
  logic [COUNT_WIDTH-1:0] load_cnt;
  logic [COUNT_WIDTH-1:0] dec_cnt   [CHANNELS];

  assign load_cnt = COUNT_WIDTH'(item.step_count);

  // next state of every channel for the current request
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      hit[i]       = (32'(item.channel) == i);
      state_nxt[i] = state_r[i];
      rem_nxt[i]   = rem_r[i];
      dir_nxt[i]   = dir_r[i];
      start_ok[i]  = 1'b0;
      step_end[i]  = 1'b0;
      dec_cnt[i]   = rem_r[i] - COUNT_WIDTH'(1);
      unique case (op_t'(item.op))
        OP_START: begin
          if (hit[i] && state_r[i] == RS_STOPPED) begin
            start_ok[i]  = 1'b1;
            state_nxt[i] = RS_PENDING;
            rem_nxt[i]   = load_cnt;
            dir_nxt[i]   = item.forward;
          end
        end
        OP_TICK: begin
          if (state_r[i] == RS_PENDING) begin
            state_nxt[i] = RS_RUNNING;
          end
        end
        OP_STEP: begin
          if (hit[i] && state_r[i] == RS_RUNNING) begin
            rem_nxt[i] = dec_cnt[i];
            if (dec_cnt[i] == '0) begin
              state_nxt[i] = RS_STOPPED;
              step_end[i]  = 1'b1;
            end
          end
        end
        OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // result fields from the updated state
  always_comb begin
    res                = '0;
    res.rejected       = (op_t'(item.op) == OP_START) && !(|start_ok);
    res.finished       = |step_end;
    for (int i = 0; i < VIS_CH; i++) begin
      res.drive_enable[i]   = (state_nxt[i] == RS_RUNNING);
      res.busy_bits[i]      = (state_nxt[i] != RS_STOPPED);
      res.direction_bits[i] = dir_nxt[i];
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        state_r[i] <= RS_STOPPED;
        rem_r[i]   <= '0;
      end
      dir_r <= '0;
    end else if (fire) begin
      for (int i = 0; i < CHANNELS; i++) begin
        state_r[i] <= state_nxt[i];
        rem_r[i]   <= rem_nxt[i];
      end
      dir_r <= dir_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // a start is never both rejected and finishing
  a_rej_fin: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> !(res.rejected && res.finished))
    else $error("rejected and finished together");

  // only a start can be rejected
  a_rej_op: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.rejected |-> (op_t'(item.op) == OP_START))
    else $error("rejected on a non-start request");

  // after a tick nothing is left pending
  a_tick: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (op_t'(item.op) == OP_TICK) |-> (res.drive_enable == res.busy_bits))
    else $error("pending channel left after tick");

  // a finished channel reads as idle and its run state is stopped next cycle
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.finished |-> (op_t'(item.op) == OP_STEP) &&
                             (VIS_CH <= 32'(item.channel) ||
                              !res.busy_bits[item.channel]))
    else $error("finished channel still busy");
`endif

endmodule

`default_nettype wire

@@ sv/multi_channel_step_run_controller.sv @@
// ---------------------------------------------------------------------------
// multi_channel_step_run_controller: step run controller for stepper channels
// Starts, arms and counts down step runs per channel; one result per request.
// ---------------------------------------------------------------------------
//  channel  | dir | contents
//  ---------+-----+------------------------------------------------------
//  in_req   | in  | op, channel, step_count, forward
//  out_res  | out | rejected, finished, drive_enable, direction_bits,
//           |     | busy_bits
//
//  one request per cycle sustained while out_res.ready stays high; a request
//  passes the input register, then channel update and result register
//  the channel state update is a single decrement and compare per channel
//  rst_n is synchronous: all channels stopped, counts and directions zero
//  a stalled result holds while the input register still takes a request,
//  and in_req.ready drops only when both registers are full
// ---------------------------------------------------------------------------
`default_nettype none

module multi_channel_step_run_controller import msrc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  msrc_in_if.sink   in_req,
  msrc_out_if.source out_res
);

  logic  in_v_r;
  item_t item_r;
  logic  out_v_r;
  res_t  res_r;
  res_t  res;
  logic  adv;
  logic  fire;

  // handshake control
  assign adv          = !out_v_r || out_res.ready;
  assign fire         = in_v_r && adv;
  assign in_req.ready = !in_v_r || fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_req.ready) begin
      in_v_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.ready && in_req.valid) begin
      item_r.op         <= in_req.op;
      item_r.channel    <= in_req.channel;
      item_r.step_count <= in_req.step_count;
      item_r.forward    <= in_req.forward;
    end
  end

  // channel state and update logic
  msrc_chan_bank u_bank (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_res.valid          = out_v_r;
  assign out_res.rejected       = res_r.rejected;
  assign out_res.finished       = res_r.finished;
  assign out_res.drive_enable   = res_r.drive_enable;
  assign out_res.direction_bits = res_r.direction_bits;
  assign out_res.busy_bits      = res_r.busy_bits;

`ifndef NO_ASSERTIONS
  // a request in the input register moves on whenever the result slot frees
  a_fire: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && (!out_v_r || out_res.ready) |=> out_v_r)
    else $error("request not advanced into result register");

  // input stalls only when both registers hold work
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_req.ready |-> in_v_r && out_v_r && !out_res.ready)
    else $error("input stalled without backpressure");

  // a driven channel is always busy
  a_en_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((out_res.drive_enable & ~out_res.busy_bits) == '0))
    else $error("drive enabled on an idle channel");
`endif

endmodule

`default_nettype wire
